[hdl/indexed_insert_remove_list_top_macros.svh]
// Assertion helpers for the checker file of the list block.
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IIRL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IIRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/iirl_pkg.sv]
package iirl_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd4;
  localparam logic [OP_W-1:0] OP_READ         = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_INS,
    S_DOWN,
    S_RD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ST_W-1:0]           status;
    logic [COUNT_W-1:0]        count;
    logic signed [VAL_W-1:0]   read_value;
  } res_t;

endpackage

[hdl/indexed_insert_remove_list_top.sv]
// Channel  | Handshake            | Word
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_ready  | in_op, in_position, in_value
// result   | out_valid / out_ready| out_status, out_count, out_read_value
//
// One word at a time. Append, remove last, insert at the end, out-of-range and
// full cases go from accept straight to the final step; a read first waits
// for the registered memory read. Insert at pos moves n - pos entries, remove
// at pos moves n - pos - 1, each moved entry taking one write on the single memory write port.
// Reset clears the length, the state and the output valid flag only; the store needs no clearing pass.
// A result holds the block in its final step until the output register takes it.
module indexed_insert_remove_list_top #(
  parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iirl_pkg::OP_W-1:0]         in_op,
  input  logic [iirl_pkg::POS_W-1:0]        in_position,
  input  logic signed [iirl_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iirl_pkg::ST_W-1:0]         out_status,
  output logic [iirl_pkg::COUNT_W-1:0]      out_count,
  output logic signed [iirl_pkg::VAL_W-1:0] out_read_value
);

  localparam int ADDR_W = $clog2(DEPTH);

  // memory port between sequencer and store
  logic                              mem_we;
  logic [ADDR_W-1:0]                 mem_waddr;
  logic signed [iirl_pkg::VAL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]                 mem_raddr;
  logic signed [iirl_pkg::VAL_W-1:0] mem_rdata;

  // finished word handed to the output register
  logic           res_valid;
  logic           res_ready;
  iirl_pkg::res_t res;

  // element store: one write, one registered read per cycle
  iirl_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer: decode, length, and the entry-by-entry shift
  iirl_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_position (in_position),
    .in_value    (in_value),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // hold the result word until the consumer takes it
  iirl_outreg u_outreg (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_read_value (out_read_value)
  );

endmodule

[hdl/iirl_mem.sv]
module iirl_mem #(
  parameter int DEPTH  = iirl_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ADDR_W-1:0]              waddr,
  input  logic signed [iirl_pkg::VAL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]              raddr,
  output logic signed [iirl_pkg::VAL_W-1:0] rdata
);

  logic signed [iirl_pkg::VAL_W-1:0] store_r [DEPTH];
  logic signed [iirl_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

[hdl/iirl_ctrl.sv]
module iirl_ctrl #(
  parameter int DEPTH  = iirl_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iirl_pkg::OP_W-1:0]           in_op,
  input  logic [iirl_pkg::POS_W-1:0]          in_position,
  input  logic signed [iirl_pkg::VAL_W-1:0]   in_value,
  // memory port
  output logic                                mem_we,
  output logic [ADDR_W-1:0]                   mem_waddr,
  output logic signed [iirl_pkg::VAL_W-1:0]   mem_wdata,
  output logic [ADDR_W-1:0]                   mem_raddr,
  input  logic signed [iirl_pkg::VAL_W-1:0]   mem_rdata,
  // finished result
  output logic                                res_valid,
  input  logic                                res_ready,
  output iirl_pkg::res_t                      res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > iirl_pkg::POS_W) ? CNT_W : iirl_pkg::POS_W;

  iirl_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]                j_r, j_nxt;
  logic [ADDR_W-1:0]                pos_r, pos_nxt;
  logic [ADDR_W-1:0]                lim_r, lim_nxt;
  logic signed [iirl_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [iirl_pkg::ST_W-1:0]        res_st_r, res_st_nxt;
  logic signed [iirl_pkg::VAL_W-1:0] res_rd_r, res_rd_nxt;

  // decode of the incoming word against the current length
  logic                      acc;
  logic [CMP_W-1:0]          n_w, p_w;
  logic                      full, empty;
  logic [iirl_pkg::ST_W-1:0] dec_st;
  logic                      dec_wr, dec_inc, dec_dec, dec_up, dec_down, dec_rd;
  logic [ADDR_W-1:0]         dec_waddr, dec_raddr;

  assign acc   = in_valid && in_ready;
  assign n_w   = CMP_W'(cnt_r);
  assign p_w   = CMP_W'(in_position);
  assign full  = (n_w == CMP_W'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    dec_st    = iirl_pkg::ST_DONE;
    dec_wr    = 1'b0;
    dec_inc   = 1'b0;
    dec_dec   = 1'b0;
    dec_up    = 1'b0;
    dec_down  = 1'b0;
    dec_rd    = 1'b0;
    dec_waddr = ADDR_W'(n_w);
    dec_raddr = ADDR_W'(p_w);
    unique case (in_op)
      iirl_pkg::OP_APPEND: begin
        if (full) begin
          dec_st = iirl_pkg::ST_FULL;
        end else begin
          dec_wr  = 1'b1;
          dec_inc = 1'b1;
        end
      end
      iirl_pkg::OP_INSERT: begin
        if (p_w > n_w) begin
          dec_st = iirl_pkg::ST_RANGE;
        end else if (full) begin
          dec_st = iirl_pkg::ST_FULL;
        end else begin
          dec_inc = 1'b1;
          if (p_w == n_w) begin
            dec_wr    = 1'b1;
            dec_waddr = ADDR_W'(p_w);
          end else begin
            dec_up    = 1'b1;
            dec_raddr = ADDR_W'(n_w - CMP_W'(1));
          end
        end
      end
      iirl_pkg::OP_REMOVE_AT: begin
        if (p_w >= n_w) begin
          dec_st = iirl_pkg::ST_RANGE;
        end else begin
          dec_dec = 1'b1;
          if (p_w != n_w - CMP_W'(1)) begin
            dec_down  = 1'b1;
            dec_raddr = ADDR_W'(p_w + CMP_W'(1));
          end
        end
      end
      iirl_pkg::OP_REMOVE_LAST: begin
        if (empty) begin
          dec_st = iirl_pkg::ST_RANGE;
        end else begin
          dec_dec = 1'b1;
        end
      end
      iirl_pkg::OP_REMOVE_FIRST: begin
        if (empty) begin
          dec_st = iirl_pkg::ST_RANGE;
        end else begin
          dec_dec = 1'b1;
          if (n_w != CMP_W'(1)) begin
            dec_down  = 1'b1;
            dec_raddr = ADDR_W'(1);
          end
        end
      end
      iirl_pkg::OP_READ: begin
        if (p_w >= n_w) begin
          dec_st = iirl_pkg::ST_RANGE;
        end else begin
          dec_rd = 1'b1;
        end
      end
      default: begin
        dec_st = iirl_pkg::ST_DONE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iirl_pkg::S_IDLE: begin
        if (acc) begin
          priority if (dec_up) begin
            state_nxt = iirl_pkg::S_UP;
          end else if (dec_down) begin
            state_nxt = iirl_pkg::S_DOWN;
          end else if (dec_rd) begin
            state_nxt = iirl_pkg::S_RD;
          end else begin
            state_nxt = iirl_pkg::S_FIN;
          end
        end
      end
      iirl_pkg::S_UP: begin
        if (j_r == pos_r) begin
          state_nxt = iirl_pkg::S_INS;
        end
      end
      iirl_pkg::S_INS:  state_nxt = iirl_pkg::S_FIN;
      iirl_pkg::S_DOWN: begin
        if (j_r == lim_r) begin
          state_nxt = iirl_pkg::S_FIN;
        end
      end
      iirl_pkg::S_RD:   state_nxt = iirl_pkg::S_FIN;
      iirl_pkg::S_FIN: begin
        if (res_ready) begin
          state_nxt = iirl_pkg::S_IDLE;
        end
      end
      default: state_nxt = iirl_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = j_r - ADDR_W'(1);
    mem_wdata  = mem_rdata;
    mem_raddr  = j_r + ADDR_W'(1);
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    lim_nxt    = lim_r;
    val_nxt    = val_r;
    res_st_nxt = res_st_r;
    res_rd_nxt = res_rd_r;
    unique case (state_r)
      iirl_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_we    = acc && dec_wr;
        mem_waddr = dec_waddr;
        mem_wdata = in_value;
        mem_raddr = dec_raddr;
        if (acc) begin
          res_st_nxt = dec_st;
          res_rd_nxt = '0;
          j_nxt      = dec_raddr;
          pos_nxt    = ADDR_W'(p_w);
          lim_nxt    = ADDR_W'(n_w - CMP_W'(1));
          val_nxt    = in_value;
          if (dec_inc) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (dec_dec) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      iirl_pkg::S_UP: begin
        // move entry j up one place, fetch the one below
        mem_we    = 1'b1;
        mem_waddr = j_r + ADDR_W'(1);
        mem_raddr = j_r - ADDR_W'(1);
        j_nxt     = j_r - ADDR_W'(1);
      end
      iirl_pkg::S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
      end
      iirl_pkg::S_DOWN: begin
        // move entry j down one place, fetch the one above
        mem_we    = 1'b1;
        mem_waddr = j_r - ADDR_W'(1);
        mem_raddr = j_r + ADDR_W'(1);
        j_nxt     = j_r + ADDR_W'(1);
      end
      iirl_pkg::S_RD: begin
        res_rd_nxt = mem_rdata;
      end
      iirl_pkg::S_FIN: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res.status     = res_st_r;
  assign res.count      = iirl_pkg::COUNT_W'(cnt_r);
  assign res.read_value = res_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iirl_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    pos_r    <= pos_nxt;
    lim_r    <= lim_nxt;
    val_r    <= val_nxt;
    res_st_r <= res_st_nxt;
    res_rd_r <= res_rd_nxt;
  end

endmodule

[hdl/iirl_outreg.sv]
module iirl_outreg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  iirl_pkg::res_t                    res,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iirl_pkg::ST_W-1:0]         out_status,
  output logic [iirl_pkg::COUNT_W-1:0]      out_count,
  output logic signed [iirl_pkg::VAL_W-1:0] out_read_value
);

  logic           out_valid_r, out_valid_nxt;
  iirl_pkg::res_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_count      = out_res_r.count;
  assign out_read_value = out_res_r.read_value;

endmodule

[hdl/iirl_chk.sv]
`include "indexed_insert_remove_list_top_macros.svh"

module iirl_chk #(
  parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [iirl_pkg::OP_W-1:0]         in_op,
  input logic [iirl_pkg::POS_W-1:0]        in_position,
  input logic signed [iirl_pkg::VAL_W-1:0] in_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [iirl_pkg::ST_W-1:0]         out_status,
  input logic [iirl_pkg::COUNT_W-1:0]      out_count,
  input logic signed [iirl_pkg::VAL_W-1:0] out_read_value
);

  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ (^in_op) ^ (^in_position) ^ (^in_value);

  `IIRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_count) && $stable(out_read_value), "result word changed while stalled")

  `IIRL_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && out_status == iirl_pkg::ST_FULL, out_count == iirl_pkg::COUNT_W'(DEPTH), "full status without a full list")

  `IIRL_ASSERT_NOW(a_rd_zero, clk, rst_n, out_valid && out_status != iirl_pkg::ST_DONE, out_read_value == '0, "read value set on a rejected word")

  `IIRL_ASSERT_NOW(a_count_max, clk, rst_n, out_valid && DEPTH < 64, int'(out_count) <= DEPTH, "length beyond capacity")

endmodule

bind indexed_insert_remove_list_top iirl_chk #(.DEPTH(DEPTH)) u_chk (.*);

[dv/iirl_list_checker.sv]
module iirl_list_checker #(
  parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [iirl_pkg::OP_W-1:0]         in_op,
  input  logic [iirl_pkg::POS_W-1:0]        in_position,
  input  logic signed [iirl_pkg::VAL_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [iirl_pkg::ST_W-1:0]         out_status,
  input  logic [iirl_pkg::COUNT_W-1:0]      out_count,
  input  logic signed [iirl_pkg::VAL_W-1:0] out_read_value,
  output int                                fail_count,
  output int                                awaited,
  output int                                list_len
);
  import iirl_pkg::*;

  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  int                      shadow_len;
  res_t                    awaited_res [$];
  res_t                    want;
  res_t                    got;
  int                      fails = 0;

  assign fail_count = fails;

  // Apply one operation to the shadow list and return the word it should produce.
  function automatic res_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic signed [VAL_W-1:0] val);
    res_t r;
    int   p;
    int   i;
    r.status     = ST_DONE;
    r.read_value = '0;
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // range check wins over the full check
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_len++;
        end
      end
      OP_REMOVE_AT: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_REMOVE_LAST: begin
        if (shadow_len == 0) r.status = ST_RANGE;
        else shadow_len--;
      end
      OP_REMOVE_FIRST: begin
        if (shadow_len == 0) begin
          r.status = ST_RANGE;
        end else begin
          for (i = 0; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_READ: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_list[p];
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_len);
    return r;
  endfunction

  task automatic flag_field(string field, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      awaited_res.delete();
    end else begin
      // results first: a word leaving now never belongs to the word entering now
      if (out_valid && out_ready) begin
        got.status     = out_status;
        got.count      = out_count;
        got.read_value = out_read_value;
        if (awaited_res.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none actual %h/%h/%h",
                   $time, got.status, got.count, got.read_value);
        end else begin
          // take the oldest awaited word off the head
          want = awaited_res[0];
          awaited_res.delete(0);
          flag_field("status", VAL_W'(want.status), VAL_W'(got.status));
          flag_field("count", VAL_W'(want.count), VAL_W'(got.count));
          flag_field("read_value", want.read_value, got.read_value);
        end
      end
      if (in_valid && in_ready) begin
        awaited_res.push_back(apply_list_op(in_op, in_position, in_value));
      end
    end
    awaited  <= awaited_res.size();
    list_len <= shadow_len;
  end

endmodule

[dv/indexed_insert_remove_list_top_tb.sv]
module indexed_insert_remove_list_top_tb;
  import iirl_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_IDLE     = 18;
  localparam int RANDOM_WORDS = 500;
  // the longest shift moves DEPTH - 1 entries
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int RUN_LIMIT    = 3_000_000;

  // op codes the block leaves undefined; it must ignore them
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // GROW favors appends and inserts, SHRINK favors removals, so the list
  // swings between empty and full many times over the run
  typedef enum logic {GROW, SHRINK} trend_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op          = OP_APPEND;
  logic [POS_W-1:0]         in_position    = '0;
  logic signed [VAL_W-1:0]  in_value       = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic [ST_W-1:0]          out_status;
  logic [COUNT_W-1:0]       out_count;
  logic signed [VAL_W-1:0]  out_read_value;

  int                       fail_count;
  int                       awaited;
  int                       list_len;

  bit                       feed_burst = 1'b0;
  trend_t                   trend      = GROW;

  always #HALF_PERIOD clk = ~clk;

  indexed_insert_remove_list_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_read_value(out_read_value)
  );

  iirl_list_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_read_value(out_read_value),
    .fail_count    (fail_count),
    .awaited       (awaited),
    .list_len      (list_len)
  );

  // Offer one word and return at the edge that accepts it. Valid drops only
  // when a gap follows, so back-to-back words keep it high with a single
  // assignment per edge.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    // flip between idle gaps and zero-gap bursts now and then
    if ($urandom_range(0, 19) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    // hold the word until an edge sees valid and ready together
    do @(posedge clk); while (!in_ready);
  endtask

  // Build one random word shaped by the list length. Most positions land
  // inside the list so inserts and removes really shift entries; a few sit
  // on the end or anywhere from 0 to DEPTH to hit the rejects.
  task automatic send_random_word(output bit counted);
    int                      len;
    int                      roll;
    int                      p_roll;
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    len = list_len;
    // linger at full and at empty for a few words before turning around
    if (len >= DEPTH && trend == GROW && $urandom_range(0, 3) == 0) trend = SHRINK;
    else if (len == 0 && trend == SHRINK && $urandom_range(0, 3) == 0) trend = GROW;

    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      op = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
    end else if (roll < 17) begin
      op = OP_READ;
    end else if ((trend == GROW && roll < 55) || (trend == SHRINK && roll < 23)) begin
      op = OP_APPEND;
    end else if ((trend == GROW && roll < 88) || (trend == SHRINK && roll < 29)) begin
      op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_REMOVE_AT;
        1:       op = OP_REMOVE_LAST;
        default: op = OP_REMOVE_FIRST;
      endcase
    end

    p_roll = $urandom_range(0, 9);
    if (p_roll == 0) pos = POS_W'($urandom_range(0, DEPTH));
    else if (p_roll == 1) pos = POS_W'(len);
    else pos = POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));

    case ($urandom_range(0, 15))
      0:       val = VAL_MIN;
      1:       val = VAL_MAX;
      2:       val = '0;
      3:       val = -1;
      default: val = $urandom();
    endcase

    send_word(op, pos, val);
    counted = (op != OP_UNUSED_LO) && (op != OP_UNUSED_HI);
  endtask

  // Result side: stall for a random number of cycles after each result
  // word taken, with runs of no stalling mixed in.
  initial begin : result_sink
    int stall;
    bit sink_burst;
    sink_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int sent;
    bit counted;
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every removal and read is out of range, insert past the end too
    send_word(OP_REMOVE_LAST, 0, '0);
    send_word(OP_REMOVE_FIRST, 0, '0);
    send_word(OP_READ, 0, '0);
    send_word(OP_REMOVE_AT, 0, '0);
    send_word(OP_INSERT, 1, 32'sd5);
    // unused codes change nothing
    send_word(OP_UNUSED_LO, 0, VAL_MAX);
    send_word(OP_UNUSED_HI, 0, VAL_MIN);

    // build a short list with the value extremes, inserting at front, middle and end
    send_word(OP_INSERT, 0, VAL_MIN);
    send_word(OP_APPEND, 0, VAL_MAX);
    send_word(OP_APPEND, 0, '0);
    send_word(OP_APPEND, 0, -1);
    send_word(OP_INSERT, 1, 32'sh1234_5678);
    send_word(OP_INSERT, 5, 32'sh0F0F_0F0F);
    send_word(OP_INSERT, 0, 32'sd1);

    // reads: first, middle, last, one past the end, position DEPTH
    send_word(OP_READ, 0, '0);
    send_word(OP_READ, 3, '0);
    send_word(OP_READ, 6, '0);
    send_word(OP_READ, 7, '0);
    send_word(OP_READ, POS_W'(DEPTH), '0);

    // removals shift the tail down; the last one falls past the new end
    send_word(OP_REMOVE_AT, 2, '0);
    send_word(OP_REMOVE_FIRST, 0, '0);
    send_word(OP_REMOVE_LAST, 0, '0);
    send_word(OP_REMOVE_AT, 4, '0);

    // random part: ignored op codes do not advance the tally
    while (sent < RANDOM_WORDS) begin
      send_random_word(counted);
      if (counted) sent++;
    end
    in_valid <= 1'b0;

    // step past an edge so the last accepted word shows up in the tally, then
    // drain every awaited result and watch a little longer for strays
    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin : watchdog
    #RUN_LIMIT;
    $display("Test completed with failures");
    $finish;
  end

endmodule
